FILE: rtl/phs_pkg.sv
package phs_pkg;

    localparam int MAX_TRACKS = 16;
    localparam int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

    localparam int Q_W   = 16;
    localparam int PRD_W = 2 * Q_W;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int EVC_W = 5;
    localparam int CFG_A_W = 2;

    localparam logic [Q_W-1:0] ONE_Q15  = 16'd32768;
    localparam logic [PRD_W-1:0] HALF_Q15 = 32'd16384;
    localparam logic [EVC_W-1:0] EVC_MAX = 5'd31;

    localparam logic [CMD_W-1:0] CMD_SEEN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    localparam logic [ST_W-1:0] ST_NEW  = 2'd0;
    localparam logic [ST_W-1:0] ST_UPD  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_ACK  = 2'd3;

    localparam logic [CFG_A_W-1:0] CFG_RISE_GAIN = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_FALL_GAIN = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_ON_THR    = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_OFF_THR   = 2'd3;

    localparam logic [15:0] RISE_GAIN_RST = 16'd21299;
    localparam logic [15:0] FALL_GAIN_RST = 16'd9830;
    localparam logic [15:0] ON_THR_RST    = 16'd18022;
    localparam logic [15:0] OFF_THR_RST   = 16'd11469;

    typedef struct packed {
        logic load;
        logic look;
        logic mul;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [Q_W-1:0] sat_one(input logic [Q_W-1:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

endpackage

FILE: rtl/per_track_hysteresis_smoother_core.sv
// Per-track hysteresis smoother. Each input beat carries a command in tuser (mark seen,
// score, close window) with the track id and a Q1.15 raw probability in tdata; every
// beat yields exactly one result beat carrying the smoothed probability, the active
// flag and the eviction count in tdata and the status in tuser. A beat passes through four
// steps: accept, table lookup over the sixteen entries, one pair of 16x16 blend
// multiplies, then the table write and result register; the next beat is taken once
// the controller is back in its idle state, and the result register lets that happen
// while the previous result still waits. Configuration writes apply on the cycle after
// the write enable and should only be issued while no beat is in flight.
module per_track_hysteresis_smoother_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [phs_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [phs_pkg::Q_W-1:0]      i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] track, [31:16] raw_prob
    input  logic [31:0]                  s_axis_tdata,
    // [1:0] command
    input  logic [phs_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] smoothed_prob, [16] is_active, [21:17] evicted_count, [23:22] zero
    output logic [23:0]                  m_axis_tdata,
    // [1:0] status
    output logic [phs_pkg::ST_W-1:0]     m_axis_tuser
);
    import phs_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [Q_W-1:0]   w_prob;
    logic             w_active;
    logic [EVC_W-1:0] w_evict;

    phs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    phs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_cmd     (s_axis_tuser),
        .i_in_id      (s_axis_tdata[15:0]),
        .i_in_raw     (s_axis_tdata[31:16]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_prob   (w_prob),
        .o_out_active (w_active),
        .o_out_status (m_axis_tuser),
        .o_out_evict  (w_evict)
    );

    assign m_axis_tdata = {2'b00, w_evict, w_active, w_prob};

endmodule

FILE: rtl/phs_ctrl.sv
module phs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  phs_pkg::t_dp_stat i_stat,
    output phs_pkg::t_dp_cmd  o_cmd
);
    import phs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.look, o_cmd.mul, o_cmd.fin}))
        else $error("more than one datapath command");

    a_fin_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !i_stat.out_free) |=> (r_state == S_FIN))
        else $error("result step left while output busy");

    a_load_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.look)
        else $error("lookup did not follow load");

endmodule

FILE: rtl/phs_dp.sv
module phs_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  phs_pkg::t_dp_cmd             i_cmd,
    output phs_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_we,
    input  logic [phs_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [phs_pkg::Q_W-1:0]      i_cfg_data,
    input  logic [phs_pkg::CMD_W-1:0]    i_in_cmd,
    input  logic [phs_pkg::Q_W-1:0]      i_in_id,
    input  logic [phs_pkg::Q_W-1:0]      i_in_raw,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [phs_pkg::Q_W-1:0]      o_out_prob,
    output logic                         o_out_active,
    output logic [phs_pkg::ST_W-1:0]     o_out_status,
    output logic [phs_pkg::EVC_W-1:0]    o_out_evict
);
    import phs_pkg::*;

    logic [Q_W-1:0] r_rise_gain;
    logic [Q_W-1:0] r_fall_gain;
    logic [Q_W-1:0] r_on_thr;
    logic [Q_W-1:0] r_off_thr;

    logic [MAX_TRACKS-1:0] r_valid;
    logic [MAX_TRACKS-1:0] r_seen;
    logic [MAX_TRACKS-1:0] r_act;
    logic [Q_W-1:0]        r_track [MAX_TRACKS];
    logic [Q_W-1:0]        r_prob  [MAX_TRACKS];

    logic [CMD_W-1:0] r_cmd;
    logic [Q_W-1:0]   r_id;
    logic [Q_W-1:0]   r_raw;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic [Q_W-1:0]   r_prev;
    logic             r_act_prev;
    logic [Q_W-1:0]   r_gain;
    logic [MAX_TRACKS-1:0] r_evict;

    logic [PRD_W-1:0] r_p0;
    logic [PRD_W-1:0] r_p1;
    logic [CNT_W-1:0] r_evcnt;

    logic             r_out_valid;
    logic [Q_W-1:0]   r_out_prob;
    logic             r_out_active;
    logic [ST_W-1:0]  r_out_status;
    logic [EVC_W-1:0] r_out_evict;

    logic             n_hit;
    logic [IDX_W-1:0] n_hit_idx;
    logic             n_free;
    logic [IDX_W-1:0] n_free_idx;
    logic [Q_W-1:0]   n_prev;
    logic [CNT_W-1:0] n_evcnt;
    logic [PRD_W-1:0] n_sum;
    logic [Q_W-1:0]   n_fused;
    logic             n_fused_act;
    logic             n_raw_act;
    logic [EVC_W-1:0] n_evict_out;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_free     = 1'b0;
        n_free_idx = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_track[i] == r_id) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                n_free     = 1'b1;
                n_free_idx = IDX_W'(i);
            end
        end
    end

    assign n_prev = r_prob[n_hit_idx];

    always_comb begin
        n_evcnt = '0;
        for (int i = 0; i < MAX_TRACKS; i++) begin
            n_evcnt = n_evcnt + CNT_W'(r_evict[i]);
        end
    end

    assign n_sum       = r_p0 + r_p1 + HALF_Q15;
    assign n_fused     = n_sum[Q_W+14:15];
    assign n_fused_act = n_fused >= (r_act_prev ? r_off_thr : r_on_thr);
    assign n_raw_act   = r_raw >= r_on_thr;
    assign n_evict_out = ({{(32-CNT_W){1'b0}}, r_evcnt} > 32'(EVC_MAX)) ? EVC_MAX
                                                                       : EVC_W'(r_evcnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_gain <= RISE_GAIN_RST;
            r_fall_gain <= FALL_GAIN_RST;
            r_on_thr    <= ON_THR_RST;
            r_off_thr   <= OFF_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RISE_GAIN: r_rise_gain <= i_cfg_data;
                CFG_FALL_GAIN: r_fall_gain <= i_cfg_data;
                CFG_ON_THR:    r_on_thr    <= i_cfg_data;
                CFG_OFF_THR:   r_off_thr   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_cmd;
            r_id  <= i_in_id;
            r_raw <= sat_one(i_in_raw);
        end
        if (i_cmd.look) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_free     <= n_free;
            r_free_idx <= n_free_idx;
            r_prev     <= n_prev;
            r_act_prev <= r_act[n_hit_idx];
            r_gain     <= sat_one((r_raw >= n_prev) ? r_rise_gain : r_fall_gain);
            r_evict    <= r_valid & ~r_seen;
        end
        if (i_cmd.mul) begin
            r_p0    <= {{Q_W{1'b0}}, ONE_Q15 - r_gain} * {{Q_W{1'b0}}, r_prev};
            r_p1    <= {{Q_W{1'b0}}, r_gain} * {{Q_W{1'b0}}, r_raw};
            r_evcnt <= n_evcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && r_cmd == CMD_SCORE) begin
            if (r_hit) begin
                r_prob[r_hit_idx] <= n_fused;
                r_act[r_hit_idx]  <= n_fused_act;
            end else if (r_free) begin
                r_track[r_free_idx] <= r_id;
                r_prob[r_free_idx]  <= r_raw;
                r_act[r_free_idx]   <= n_raw_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_seen  <= '0;
        end else if (i_cmd.fin) begin
            case (r_cmd)
                CMD_SEEN: begin
                    if (r_hit) begin
                        r_seen[r_hit_idx] <= 1'b1;
                    end
                end
                CMD_SCORE: begin
                    if (r_hit) begin
                        r_seen[r_hit_idx] <= 1'b1;
                    end else if (r_free) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_seen[r_free_idx]  <= 1'b1;
                    end
                end
                CMD_CLOSE: begin
                    r_valid <= r_valid & ~r_evict;
                    r_seen  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_prob   <= '0;
            r_out_active <= 1'b0;
            r_out_status <= ST_ACK;
            r_out_evict  <= '0;
            case (r_cmd)
                CMD_SCORE: begin
                    if (r_hit) begin
                        r_out_prob   <= n_fused;
                        r_out_active <= n_fused_act;
                        r_out_status <= ST_UPD;
                    end else begin
                        r_out_prob   <= r_raw;
                        r_out_active <= n_raw_act;
                        r_out_status <= r_free ? ST_NEW : ST_FULL;
                    end
                end
                CMD_CLOSE: begin
                    r_out_evict <= n_evict_out;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_prob   = r_out_prob;
    assign o_out_active = r_out_active;
    assign o_out_status = r_out_status;
    assign o_out_evict  = r_out_evict;

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && r_cmd == CMD_SCORE && r_hit) |-> (n_fused <= ONE_Q15))
        else $error("blend left the unit range");

    a_close_clears_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && r_cmd == CMD_CLOSE) |=> (r_seen == '0))
        else $error("seen marks not cleared by close");

    a_evict_only_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_ACK) |-> (r_out_evict == '0))
        else $error("eviction count on a score beat");

    a_seen_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> ((r_seen & ~r_valid) == '0))
        else $error("seen mark on a free entry");

endmodule

FILE: sim/tb_per_track_hysteresis_smoother_core.sv
module tb_per_track_hysteresis_smoother_core;
    import phs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam logic [31:0] Q15_ONE  = 32'd32768;
    localparam logic [31:0] Q15_HALF = 32'd16384;
    localparam logic [15:0] RISE_DEFAULT = 16'd21299;
    localparam logic [15:0] FALL_DEFAULT = 16'd9830;
    localparam logic [15:0] ON_DEFAULT   = 16'd18022;
    localparam logic [15:0] OFF_DEFAULT  = 16'd11469;
    localparam int POOL_DEPTH   = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 12;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct {
        logic [15:0] prob;
        logic        active;
        logic [1:0]  status;
        logic [4:0]  evicted;
    } t_smooth_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_addr = '0;
    logic [Q_W-1:0]       i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic [ST_W-1:0]      m_axis_tuser;

    logic [15:0] gain_rise, gain_fall, thr_on, thr_off;
    logic        tbl_valid  [MAX_TRACKS];
    logic [15:0] tbl_track  [MAX_TRACKS];
    logic [15:0] tbl_prob   [MAX_TRACKS];
    logic        tbl_active [MAX_TRACKS];
    logic        tbl_seen   [MAX_TRACKS];

    t_smooth_result expected_results[$];
    t_smooth_result due;
    logic [15:0] track_pool [POOL_DEPTH];

    int       fail_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    logic     tx_gaps = 1'b1;
    logic     hold_request = 1'b0;
    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_duty = 70;
    int       rx_period = 4;
    int       rx_on = 3;

    per_track_hysteresis_smoother_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] clamp_q15(input logic [15:0] v);
        return (v > 16'd32768) ? Q15_ONE : {16'd0, v};
    endfunction

    function automatic t_smooth_result smooth_track(input logic [CMD_W-1:0] cmd,
            input logic [15:0] id, input logic [15:0] raw_in);
        t_smooth_result res;
        logic [31:0] raw, gain, prev, fused;
        logic now_active;
        int hit, spare;
        res = '{prob: '0, active: 1'b0, status: ST_ACK, evicted: '0};
        raw = clamp_q15(raw_in);
        hit = -1;
        spare = -1;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_track[i] == id) hit = i;
            if (!tbl_valid[i]) spare = i;
        end
        case (cmd)
            CMD_SEEN: begin
                if (hit >= 0) tbl_seen[hit] = 1'b1;
            end
            CMD_SCORE: begin
                if (hit >= 0) begin
                    prev = {16'd0, tbl_prob[hit]};
                    gain = clamp_q15(raw >= prev ? gain_rise : gain_fall);
                    fused = ((Q15_ONE - gain) * prev + gain * raw + Q15_HALF) >> 15;
                    now_active = fused >= {16'd0, (tbl_active[hit] ? thr_off : thr_on)};
                    tbl_prob[hit] = fused[15:0];
                    tbl_active[hit] = now_active;
                    tbl_seen[hit] = 1'b1;
                    res.prob = fused[15:0];
                    res.active = now_active;
                    res.status = ST_UPD;
                end else begin
                    now_active = raw >= {16'd0, thr_on};
                    res.prob = raw[15:0];
                    res.active = now_active;
                    if (spare >= 0) begin
                        tbl_valid[spare] = 1'b1;
                        tbl_track[spare] = id;
                        tbl_prob[spare] = raw[15:0];
                        tbl_active[spare] = now_active;
                        tbl_seen[spare] = 1'b1;
                        res.status = ST_NEW;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
            end
            CMD_CLOSE: begin
                for (int i = 0; i < MAX_TRACKS; i++) begin
                    if (tbl_valid[i] && !tbl_seen[i]) begin
                        tbl_valid[i] = 1'b0;
                        if (res.evicted != 5'd31) res.evicted++;
                    end
                    tbl_seen[i] = 1'b0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [15:0] pick_raw();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return 16'd0;
        if (roll < 16) return 16'd32768;
        if (roll < 26) return 16'($urandom_range(32769, 65535));
        if (roll < 36) return thr_on + 16'($urandom_range(0, 6)) - 16'd3;
        if (roll < 46) return thr_off + 16'($urandom_range(0, 6)) - 16'd3;
        return 16'($urandom_range(0, 32768));
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [15:0] id,
            input logic [15:0] raw);
        if (burst_left == 0) begin
            if (tx_gaps) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {raw, id};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expected_results = {expected_results, smooth_track(cmd, id, raw)};
        burst_left--;
    endtask

    task automatic sender_rest();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RISE_GAIN: gain_rise = val;
            CFG_FALL_GAIN: gain_fall = val;
            CFG_ON_THR:    thr_on = val;
            default:       thr_off = val;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] rise, input logic [15:0] fall,
            input logic [15:0] on_lvl, input logic [15:0] off_lvl);
        sender_rest();
        wait_drained();
        write_reg(CFG_RISE_GAIN, rise);
        write_reg(CFG_FALL_GAIN, fall);
        write_reg(CFG_ON_THR, on_lvl);
        write_reg(CFG_OFF_THR, off_lvl);
    endtask

    task automatic pick_idling();
        tx_gaps = 1'b1;
        rx_mode = t_rx_mode'($urandom_range(0, 2));
        rx_duty = $urandom_range(30, 95);
        rx_period = $urandom_range(2, 9);
        rx_on = $urandom_range(1, rx_period - 1);
    endtask

    task automatic run_windows(input int beats);
        int counted, wsize, pool_n, roll;
        logic [15:0] id;
        counted = 0;
        while (counted < beats) begin
            repeat ($urandom_range(0, 3))
                track_pool[$urandom_range(0, POOL_DEPTH - 1)] = 16'($urandom);
            pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, POOL_DEPTH)
                                                 : $urandom_range(2, 15);
            wsize = $urandom_range(3, 30);
            for (int k = 0; k < wsize; k++) begin
                roll = $urandom_range(0, 99);
                id = track_pool[$urandom_range(0, pool_n - 1)];
                if (roll < 62) send_beat(CMD_SCORE, id, pick_raw());
                else if (roll < 82) send_beat(CMD_SEEN, id, 16'($urandom));
                else if (roll < 89) send_beat(CMD_SCORE, 16'($urandom), pick_raw());
                else if (roll < 94) send_beat(CMD_SEEN, 16'($urandom), 16'($urandom));
                else if (roll < 97) send_beat(CMD_SPARE, 16'($urandom), 16'($urandom));
                else send_beat(CMD_CLOSE, 16'($urandom), 16'($urandom));
                if (roll < 94 || roll >= 97) counted++;
            end
            send_beat(CMD_CLOSE, 16'($urandom), 16'($urandom));
            counted++;
        end
    endtask

    task automatic test_directed_commands();
        pick_idling();
        send_beat(CMD_SEEN, 16'h1234, 16'd0);
        send_beat(CMD_SPARE, 16'hFFFF, 16'hFFFF);
        send_beat(CMD_CLOSE, 16'hFFFF, 16'hFFFF);
        send_beat(CMD_SCORE, 16'h0000, 16'd0);
        send_beat(CMD_SCORE, 16'hFFFF, 16'hFFFF);
        send_beat(CMD_SCORE, 16'hFFFF, 16'd0);
        send_beat(CMD_SCORE, 16'hFFFF, 16'd32768);
        send_beat(CMD_SCORE, 16'h0000, ON_DEFAULT);
        send_beat(CMD_SCORE, 16'h0000, 16'd32768);
        send_beat(CMD_SCORE, 16'h0000, OFF_DEFAULT);
        send_beat(CMD_SEEN, 16'h0000, 16'd0);
        send_beat(CMD_CLOSE, 16'h0000, 16'd0);
        send_beat(CMD_SEEN, 16'hFFFF, 16'd0);
        send_beat(CMD_CLOSE, 16'h0000, 16'd0);
        send_beat(CMD_CLOSE, 16'h0000, 16'd0);
    endtask

    task automatic test_table_full();
        for (int k = 0; k < MAX_TRACKS; k++)
            send_beat(CMD_SCORE, 16'h0100 + 16'(k),
                      k == 0 ? ON_DEFAULT : k == 1 ? ON_DEFAULT - 16'd1 : pick_raw());
        send_beat(CMD_SCORE, 16'hBEEF, ON_DEFAULT);
        send_beat(CMD_CLOSE, 16'h0000, 16'd0);
        send_beat(CMD_CLOSE, 16'h0000, 16'd0);
    endtask

    task automatic test_random_defaults();
        pick_idling();
        run_windows(300);
    endtask

    task automatic test_setting_extremes();
        apply_settings(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        pick_idling();
        run_windows(100);
        apply_settings(16'd0, 16'd32768, 16'd32768, 16'd0);
        pick_idling();
        run_windows(100);
        apply_settings(16'd32768, 16'd32769, 16'hFFFF, 16'd32769);
        pick_idling();
        run_windows(100);
    endtask

    task automatic test_random_settings();
        logic [15:0] v [4];
        repeat (3) begin
            foreach (v[k])
                v[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 32768));
            apply_settings(v[0], v[1], v[2], v[3]);
            pick_idling();
            run_windows(120);
        end
    endtask

    task automatic test_backpressure();
        apply_settings(RISE_DEFAULT, FALL_DEFAULT, ON_DEFAULT, OFF_DEFAULT);
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        hold_request = 1'b1;
        run_windows(60);
        sender_rest();
        wait_drained();
        pick_idling();
        run_windows(60);
    endtask

    task automatic test_no_idle();
        sender_rest();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        run_windows(150);
    endtask

    // receiver side
    initial begin : rx_side
        int tick;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < rx_duty);
                default:   m_axis_tready <= ((tick % rx_period) < rx_on);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                due = expected_results.pop_front();
                if (m_axis_tdata[15:0] !== due.prob) begin
                    $error("smoothed_prob expected %0d got %0d", due.prob, m_axis_tdata[15:0]);
                    fail_count++;
                end
                if (m_axis_tdata[16] !== due.active) begin
                    $error("is_active expected %0d got %0d", due.active, m_axis_tdata[16]);
                    fail_count++;
                end
                if (m_axis_tdata[21:17] !== due.evicted) begin
                    $error("evicted_count expected %0d got %0d", due.evicted,
                           m_axis_tdata[21:17]);
                    fail_count++;
                end
                if (m_axis_tuser !== due.status) begin
                    $error("status expected %0d got %0d", due.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        gain_rise = RISE_DEFAULT;
        gain_fall = FALL_DEFAULT;
        thr_on = ON_DEFAULT;
        thr_off = OFF_DEFAULT;
        foreach (tbl_valid[k]) begin
            tbl_valid[k] = 1'b0;
            tbl_seen[k] = 1'b0;
            tbl_track[k] = '0;
            tbl_prob[k] = '0;
            tbl_active[k] = 1'b0;
        end
        foreach (track_pool[k]) track_pool[k] = 16'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_commands();
        test_table_full();
        test_random_defaults();
        test_setting_extremes();
        test_random_settings();
        test_backpressure();
        test_no_idle();

        sender_rest();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
